// ----- src/sorted_key_table_core_defines.svh -----
// Assertion macros of the sorted key table RTL, used by skt_seq.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted key table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted key table: next-cycle check failed");

`endif

// ----- src/skt_pkg.sv -----
// Shared types and constants of the sorted key table.
// No dependencies; used by the interfaces, the sequencer and the top level.
package skt_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 7;

	localparam logic KIND_SEARCH = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] entry_count;
		logic             status;
	} res_t;

endpackage

// ----- src/skt_cmd_if.sv -----
// Request channel of the sorted key table: operation kind and key.
// Depends on skt_pkg.
interface skt_cmd_if;
	import skt_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [KEY_W-1:0]  key;

	modport source (output valid, output kind, output key, input ready);
	modport sink (input valid, input kind, input key, output ready);
endinterface

// ----- src/skt_rsp_if.sv -----
// Response channel of the sorted key table: search result, count and status.
// Depends on skt_pkg.
interface skt_rsp_if;
	import skt_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	logic [POS_W-1:0] entry_count;
	logic             status;

	modport source (output valid, output found, output position, output entry_count,
		output status, input ready);
	modport sink (input valid, input found, input position, input entry_count,
		input status, output ready);
endinterface

// ----- src/skt_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/skt_seq.sv -----
// Sequencer of the sorted key table: binary search over the key RAM with one
// shared signed comparator, then the entry-by-entry shift and key write on insert.
// Depends on skt_pkg and sorted_key_table_core_defines.svh.
`include "sorted_key_table_core_defines.svh"

module skt_seq #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     kind,
	input  logic [skt_pkg::KEY_W-1:0] key,
	output logic                     busy,
	output logic                     done,
	output skt_pkg::res_t            res,
	input  logic                     res_take,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [KEY_BITS-1:0]      ram_wdata,
	output logic [AW-1:0]            ram_raddr,
	input  logic [KEY_BITS-1:0]      ram_rdata
);
	import skt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PROBE = 6'b000010,
		ST_CMP   = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_PUT   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	logic                kind_q;
	logic [KEY_BITS-1:0] want_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [AW-1:0]       mid_q;
	logic [CW-1:0]       cnt_q;
	logic                found_q;
	logic [CW-1:0]       pos_q;
	logic                status_q;
	logic [CW-1:0]       src_q;
	logic                pend_q;
	logic [AW-1:0]       dst_q;

	logic [KEY_BITS+KEY_W-1:0] key_ext;
	logic [KEY_BITS-1:0]       key_k;
	logic [CW:0]               mid_sum;
	logic [CW-1:0]             mid_w;
	logic [AW-1:0]             mid_c;
	logic [CW-1:0]             mid_q_w;
	logic                      less;
	logic                      equal;
	logic                      fin;
	logic                      fin_found;
	logic [CW-1:0]             fin_pos;
	logic                      rd_more;
	logic [CW-1:0]             src_m1;
	logic [CW+POS_W-1:0]       pos_ext;
	logic [CW+POS_W-1:0]       cnt_ext;

	assign key_ext = {{KEY_BITS{1'b0}}, key};
	assign key_k   = key_ext[KEY_BITS-1:0];

	// Probe index (lo + hi - 1) / 2 over the half-open range [lo, hi).
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid_w   = mid_sum[CW:1];
	assign mid_c   = mid_w[AW-1:0];
	assign mid_q_w = CW'(mid_q);

	assign less  = $signed(want_q) < $signed(ram_rdata);
	assign equal = want_q == ram_rdata;

	assign rd_more = src_q > pos_q;
	assign src_m1  = src_q - {{(CW-1){1'b0}}, 1'b1};

	always_comb begin
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_pos   = lo_q;
		case (state_q)
			ST_PROBE: begin
				fin = !(lo_q < hi_q);
			end
			ST_CMP: begin
				fin       = equal;
				fin_found = equal;
				fin_pos   = mid_q_w;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		ram_raddr = mid_c;
		case (state_q)
			ST_SHIFT: begin
				ram_raddr = src_m1[AW-1:0];
				ram_we    = pend_q;
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = want_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (!fin) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!fin) begin
						state_q <= ST_PROBE;
					end
				end
				ST_SHIFT: begin
					pend_q <= rd_more;
					if (!rd_more) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					cnt_q   <= cnt_q + {{(CW-1){1'b0}}, 1'b1};
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin) begin
				if (kind_q == KIND_INSERT && cnt_q < CW'(DEPTH)) begin
					state_q <= ST_SHIFT;
					pend_q  <= 1'b0;
				end else begin
					state_q <= ST_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q   <= kind;
			want_q   <= key_k;
			lo_q     <= '0;
			hi_q     <= cnt_q;
			status_q <= STATUS_OK;
		end
		if (state_q == ST_PROBE && !fin) begin
			mid_q <= mid_c;
		end
		if (state_q == ST_CMP && !fin) begin
			if (less) begin
				hi_q <= mid_q_w;
			end else begin
				lo_q <= mid_q_w + {{(CW-1){1'b0}}, 1'b1};
			end
		end
		if (fin) begin
			found_q <= fin_found;
			pos_q   <= fin_pos;
			src_q   <= cnt_q;
			if (kind_q == KIND_INSERT && !(cnt_q < CW'(DEPTH))) begin
				status_q <= STATUS_FULL;
			end
		end
		if (state_q == ST_SHIFT && rd_more) begin
			src_q <= src_m1;
			dst_q <= src_q[AW-1:0];
		end
	end

	assign pos_ext = {{POS_W{1'b0}}, pos_q};
	assign cnt_ext = {{POS_W{1'b0}}, cnt_q};

	assign busy             = state_q != ST_IDLE;
	assign done             = state_q == ST_DONE;
	assign res.found        = found_q;
	assign res.position     = pos_ext[POS_W-1:0];
	assign res.entry_count  = cnt_ext[POS_W-1:0];
	assign res.status       = status_q;

	`SKT_ASSERT_IMPL(a_count_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`SKT_ASSERT_IMPL(a_probe_in_range, state_q == ST_CMP, (mid_q_w >= lo_q) && (mid_q_w < hi_q))
	`SKT_ASSERT_NEXT(a_put_increments, state_q == ST_PUT, cnt_q == $past(cnt_q) + 1'b1)
	`SKT_ASSERT_NEXT(a_count_holds, state_q != ST_PUT, $stable(cnt_q))

endmodule

// ----- src/sorted_key_table_core.sv -----
// Sorted key table: an ascending table of signed keys searched by bisection.
// Channels: cmd (request: kind, key) is a sink; rsp (response) is a source.
// A request is taken only when the table is idle; ready is low while it works.
// One signed comparator is shared over all probes; every probe takes a PROBE and
// a CMP state because the key RAM has a registered read port. A search makes at
// most ceil(log2(count + 1)) probes. An insert then moves the (count - position)
// keys above its position, with one RAM read and write per moved key, then writes
// the new key. An insert into a full table moves nothing. The next request can be
// taken in the cycle after a result enters the output register.
// The response sits in an output register; the table accepts the next request
// while it waits, but only delivers the next result once the register is taken.
// Reset empties the table at once: the count clears and no RAM sweep is needed.
// Depends on skt_pkg, skt_cmd_if, skt_rsp_if, skt_ram and skt_seq.
module sorted_key_table_core #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	skt_cmd_if.sink  cmd,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                busy;
	logic                done;
	logic                start;
	logic                res_take;
	res_t                res;
	res_t                rsp_q;
	logic                rsp_valid_q;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	assign cmd.ready = !busy;
	assign start     = cmd.valid && !busy;
	assign res_take  = done && (!rsp_valid_q || rsp.ready);

	skt_seq #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (cmd.kind),
		.key       (cmd.key),
		.busy      (busy),
		.done      (done),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	skt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_q.found;
	assign rsp.position    = rsp_q.position;
	assign rsp.entry_count = rsp_q.entry_count;
	assign rsp.status      = rsp_q.status;

endmodule

// ----- tb/sorted_key_table_core_test.sv -----
`timescale 1ns / 100ps
// Testbench of sorted_key_table_core: named tests drive search and insert requests
// and check every response against a predictor of the sorted table.
// Depends on skt_pkg, skt_cmd_if, skt_rsp_if and the sorted_key_table_core RTL.
module sorted_key_table_core_test;
	import skt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam int SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;

	skt_cmd_if cmd_bus ();
	skt_rsp_if rsp_bus ();

	sorted_key_table_core #(
		.DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus)
	);

	logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
	int table_count;
	res_t pending_results [$];
	res_t oldest_result;
	int mismatches;
	bit idling_on;
	int hold_off_cycles;
	int rsp_stall_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("** sorted_key_table_core: FAILED **");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idling_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Binary search with a true signed compare; an insert shifts the upper entries.
	function automatic res_t apply_request(input logic kind, input logic [KEY_W-1:0] key);
		int lo;
		int hi;
		int mid;
		int pos;
		bit hit;
		res_t r;
		lo = 0;
		hi = table_count - 1;
		mid = 0;
		hit = 1'b0;
		while (lo <= hi && !hit) begin
			mid = (lo + hi) / 2;
			if ($signed(key) < table_keys[mid])
				hi = mid - 1;
			else if ($signed(key) > table_keys[mid])
				lo = mid + 1;
			else
				hit = 1'b1;
		end
		pos = hit ? mid : lo;
		r.status = STATUS_OK;
		if (kind == KIND_INSERT) begin
			if (table_count >= TABLE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				for (int i = table_count; i > pos; i--)
					table_keys[i] = table_keys[i-1];
				table_keys[pos] = key;
				table_count++;
			end
		end
		r.found = hit;
		r.position = POS_W'(pos);
		r.entry_count = POS_W'(table_count);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0: k = KEY_MIN;
			1: k = KEY_MAX;
			2, 3: k = KEY_W'(int'($urandom_range(0, 6)) - 3);
			4, 5: begin
				if (table_count > 0)
					k = table_keys[$urandom_range(0, table_count - 1)];
				else
					k = $urandom;
			end
			6: begin
				if (table_count > 0)
					k = table_keys[$urandom_range(0, table_count - 1)]
						+ KEY_W'(int'($urandom_range(0, 2)) - 1);
				else
					k = $urandom;
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic kind, input logic [KEY_W-1:0] key);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.kind <= kind;
		cmd_bus.key <= key;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		pending_results.push_back(apply_request(kind, key));
		@(negedge clk);
	endtask

	task automatic send_random(input int n, input int insert_pct);
		for (int i = 0; i < n; i++) begin
			idling_on = (i % 100) >= 30;
			send_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SEARCH,
				pick_key());
		end
		idling_on = 1'b1;
	endtask

	task automatic test_empty_table();
		send_request(KIND_SEARCH, '0);
		send_request(KIND_SEARCH, KEY_MIN);
		send_request(KIND_SEARCH, KEY_MAX);
	endtask

	task automatic test_extremes();
		send_request(KIND_INSERT, KEY_MAX);
		send_request(KIND_INSERT, KEY_MIN);
		send_request(KIND_INSERT, '0);
		send_request(KIND_INSERT, '1);
		send_request(KIND_INSERT, KEY_W'(1));
		send_request(KIND_SEARCH, KEY_MIN);
		send_request(KIND_SEARCH, KEY_MAX);
		send_request(KIND_SEARCH, '1);
		send_request(KIND_SEARCH, KEY_W'(2));
	endtask

	task automatic test_duplicates();
		repeat (3)
			send_request(KIND_INSERT, KEY_W'(5));
		send_request(KIND_INSERT, KEY_MIN);
		send_request(KIND_SEARCH, KEY_W'(5));
		send_request(KIND_SEARCH, KEY_MIN);
	endtask

	task automatic test_random_fill();
		send_random(200, 22);
	endtask

	// The receiver holds off while requests keep coming, so the table stalls its input.
	task automatic test_back_pressure();
		idling_on = 1'b0;
		hold_off_cycles = 400;
		repeat (16)
			send_request(($urandom_range(0, 1) == 1) ? KIND_INSERT : KIND_SEARCH, pick_key());
		idling_on = 1'b1;
	endtask

	task automatic test_full_table();
		while (table_count < TABLE_DEPTH)
			send_request(KIND_INSERT, pick_key());
		send_request(KIND_INSERT, KEY_MIN);
		send_request(KIND_INSERT, KEY_MAX);
		send_request(KIND_INSERT, table_keys[TABLE_DEPTH / 2]);
		send_request(KIND_SEARCH, table_keys[TABLE_DEPTH - 1]);
	endtask

	task automatic test_random_full();
		send_random(520, 30);
	endtask

	initial begin
		rsp_bus.ready = 1'b0;
		rsp_stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				rsp_stall_left = hold_off_cycles;
				hold_off_cycles = 0;
			end else if (rsp_stall_left == 0 && $urandom_range(0, 3) == 0) begin
				rsp_stall_left = pick_gap();
			end
			rsp_bus.ready <= (rsp_stall_left == 0);
			if (rsp_stall_left > 0)
				rsp_stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response with no request outstanding", rsp_bus.position, 0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (rsp_bus.found !== oldest_result.found)
					report_mismatch("found", rsp_bus.found, oldest_result.found);
				if (rsp_bus.position !== oldest_result.position)
					report_mismatch("position", rsp_bus.position, oldest_result.position);
				if (rsp_bus.entry_count !== oldest_result.entry_count)
					report_mismatch("entry_count", rsp_bus.entry_count,
						oldest_result.entry_count);
				if (rsp_bus.status !== oldest_result.status)
					report_mismatch("status", rsp_bus.status, oldest_result.status);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.kind = KIND_SEARCH;
		cmd_bus.key = '0;
		table_count = 0;
		mismatches = 0;
		idling_on = 1'b1;
		hold_off_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_extremes();
		test_duplicates();
		test_random_fill();
		test_back_pressure();
		test_full_table();
		test_random_full();

		cmd_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** sorted_key_table_core: PASSED **");
		else
			$display("** sorted_key_table_core: FAILED **");
		$finish;
	end
endmodule

// ----- sorted_key_table_core.f -----
+incdir+src
src/skt_pkg.sv
src/skt_cmd_if.sv
src/skt_rsp_if.sv
src/skt_ram.sv
src/skt_seq.sv
src/sorted_key_table_core.sv
tb/sorted_key_table_core_test.sv
